// ===== rtl/core/knapsack_01_dp_defines.svh =====
// assertion macros shared by the knapsack engine modules
// expects signals named clk and rst_n in the including module
`ifndef KNAPSACK_01_DP_DEFINES_SVH
`define KNAPSACK_01_DP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KS01_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KS01_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ks01_pkg.sv =====
// shared constants, types and helper functions of the knapsack engine
// no dependencies
package ks01_pkg;

  localparam int MAX_CAPACITY_ENTRIES = 1024;
  localparam int ADDR_W   = $clog2(MAX_CAPACITY_ENTRIES);
  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 10;
  localparam int CAP_W    = 10;
  localparam int SUM_W    = 32;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [VALUE_W-1:0]  val_t;
  typedef logic [WEIGHT_W-1:0] wgt_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [SUM_W-1:0]    sum_t;

  localparam cap_t CAP_RESET = cap_t'(1023);

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the input item, point the counter at the capacity
    logic upd;         // issue table reads for one update step, count down
    logic sweep_init;  // clear best trackers, counter to zero
    logic sweep;       // issue one scan-and-clear step, count up
    logic emit;        // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fits;        // object weight within capacity
    logic upd_done;    // counter has reached the object weight
    logic sweep_done;  // counter at the top table entry
    logic last;        // latched last-item flag
    logic out_busy;    // result register full and stalled
  } sts_t;

  // capacity clamped to the table
  function automatic addr_t eff_cap(input cap_t c);
    if (32'(c) > 32'(MAX_CAPACITY_ENTRIES - 1)) begin
      eff_cap = addr_t'(MAX_CAPACITY_ENTRIES - 1);
    end else begin
      eff_cap = addr_t'(c);
    end
  endfunction

  // saturating table entry plus object value
  function automatic sum_t sat_add(input sum_t a, input val_t v);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - VALUE_W){1'b0}}, v};
    if (s[SUM_W]) begin
      sat_add = '1;
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/knapsack_01_dp.sv =====
// top level of the 0/1 knapsack engine
// depends on ks01_pkg, ks01_ctrl, ks01_dp (and through it ks01_ram)
//
// usage:
// - input channel (in_valid / in_stall): one object per transfer, value,
//   weight and a last flag; the engine takes one object at a time
// - result channel (out_valid / out_stall): one transfer per case, after the
//   object flagged last: best total value (saturated at 32 bits) and the
//   smallest total weight reaching it
// - config channel (cfg_valid / cfg_ready): writes the capacity, always ready;
//   write it only while the engine is idle
// - processing: an object is worked one table entry per cycle through the table
//   memories, from the capacity down to its weight (skipped if it does not fit);
//   a last object adds a scan that also clears all 1024 entries, then the result
//   register is loaded
// - reset: clearing pass over the table, in_stall high meanwhile;
//   capacity resets to 1023
// - a stalled result holds in its register; the next case may run behind it
//   and waits only at its own result until the register frees
module knapsack_01_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ks01_pkg::val_t        in_item_value,
  input  ks01_pkg::wgt_t        in_item_weight,
  input  logic                  in_last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ks01_pkg::sum_t        out_best_value,
  output ks01_pkg::wgt_t        out_best_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  ks01_pkg::cap_t        cfg_capacity
);
  import ks01_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: reset sweep, update loop, scan-and-clear, result hand-off
  ks01_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, saturating add/max, best tracker and result register
  ks01_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_item_value   (in_item_value),
    .in_item_weight  (in_item_weight),
    .in_last_item    (in_last_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_value  (out_best_value),
    .out_best_weight (out_best_weight)
  );

endmodule

// ===== rtl/core/ks01_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ks01_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ks01_ctrl.sv =====
// sequencing state machine of the knapsack engine
// depends on ks01_pkg and knapsack_01_dp_defines.svh
`include "knapsack_01_dp_defines.svh"

module ks01_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ks01_pkg::sts_t sts,
  output ks01_pkg::cmd_t cmd
);
  import ks01_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_SWEND = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_INIT: begin
        cmd.sweep_init = 1'b1;
        emit_nxt       = 1'b0;
        state_nxt      = S_SWEEP;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.fits) begin
          cmd.upd = 1'b1;
          if (sts.upd_done) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last write of the object lands here
        if (sts.last) begin
          cmd.sweep_init = 1'b1;
          emit_nxt       = 1'b1;
          state_nxt      = S_SWEEP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_SWEND;
        end
      end
      S_SWEND: begin
        state_nxt = emit_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  `KS01_ASSERT_HOLDS(a_cmd_excl, 1'b1, $onehot0({cmd.load, cmd.upd, cmd.sweep_init, cmd.sweep, cmd.emit}), "ks01_ctrl: overlapping commands")
  `KS01_ASSERT_HOLDS(a_upd_fits, cmd.upd, sts.fits, "ks01_ctrl: update step for an object that does not fit")
  `KS01_ASSERT_NEXT(a_sweep_stop, (cmd.sweep && sts.sweep_done), !cmd.sweep, "ks01_ctrl: sweep ran past the table")

endmodule

// ===== rtl/core/ks01_dp.sv =====
// datapath of the knapsack engine: table memories, update and scan logic, result register
// depends on ks01_pkg, ks01_ram and knapsack_01_dp_defines.svh
`include "knapsack_01_dp_defines.svh"

module ks01_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ks01_pkg::cmd_t        cmd,
  output ks01_pkg::sts_t        sts,
  input  ks01_pkg::val_t        in_item_value,
  input  ks01_pkg::wgt_t        in_item_weight,
  input  logic                  in_last_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  ks01_pkg::cap_t        cfg_capacity,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ks01_pkg::sum_t        out_best_value,
  output ks01_pkg::wgt_t        out_best_weight
);
  import ks01_pkg::*;

  cap_t  cap_r;
  val_t  val_r;
  wgt_t  wgt_r;
  logic  last_r;
  addr_t cnt_r, cnt_nxt;
  logic  rd_vld_r;
  logic  rd_upd_r;
  addr_t lag_addr_r;
  sum_t  best_val_r, best_val_nxt;
  addr_t best_at_r, best_at_nxt;
  logic  out_valid_r;
  sum_t  out_val_r;
  wgt_t  out_wgt_r;

  addr_t cap_eff;
  addr_t raddr_b;
  sum_t  rdata_a, rdata_b;
  sum_t  cand;
  sum_t  wdata;

  assign cap_eff = eff_cap(cap_r);
  assign raddr_b = cnt_r - addr_t'(wgt_r);

  // two copies of the table; the second gives the read at c - w
  ks01_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CAPACITY_ENTRIES)) u_tab_a (
    .clk   (clk),
    .we    (rd_vld_r),
    .waddr (lag_addr_r),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata_a)
  );

  ks01_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CAPACITY_ENTRIES)) u_tab_b (
    .clk   (clk),
    .we    (rd_vld_r),
    .waddr (lag_addr_r),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // update writes the max, sweep writes zero
  always_comb begin
    cand = sat_add(rdata_b, val_r);
    if (rd_upd_r) begin
      wdata = (cand > rdata_a) ? cand : rdata_a;
    end else begin
      wdata = '0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = cap_eff;
    end else if (cmd.upd) begin
      cnt_nxt = cnt_r - addr_t'(1);
    end else if (cmd.sweep_init) begin
      cnt_nxt = '0;
    end else if (cmd.sweep) begin
      cnt_nxt = cnt_r + addr_t'(1);
    end
  end

  // strict compare keeps the smallest index of the maximum
  always_comb begin
    best_val_nxt = best_val_r;
    best_at_nxt  = best_at_r;
    if (cmd.sweep_init) begin
      best_val_nxt = '0;
      best_at_nxt  = '0;
    end else if (rd_vld_r && !rd_upd_r && (lag_addr_r <= cap_eff) &&
                 (rdata_a > best_val_r)) begin
      best_val_nxt = rdata_a;
      best_at_nxt  = lag_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_capacity;
      end
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.upd | cmd.sweep;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_item_value;
      wgt_r  <= in_item_weight;
      last_r <= in_last_item;
    end
    rd_upd_r   <= cmd.upd;
    lag_addr_r <= cnt_r;
    best_val_r <= best_val_nxt;
    best_at_r  <= best_at_nxt;
    if (cmd.emit) begin
      out_val_r <= best_val_r;
      out_wgt_r <= wgt_t'(best_at_r);
    end
  end

  assign sts.fits       = 32'(wgt_r) <= 32'(cap_eff);
  assign sts.upd_done   = 32'(cnt_r) == 32'(wgt_r);
  assign sts.sweep_done = cnt_r == addr_t'(MAX_CAPACITY_ENTRIES - 1);
  assign sts.last       = last_r;
  assign sts.out_busy   = out_valid_r & out_stall;

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_best_value  = out_val_r;
  assign out_best_weight = out_wgt_r;

  `KS01_ASSERT_HOLDS(a_emit_free, cmd.emit, !(out_valid_r && out_stall), "ks01_dp: result overwritten while stalled")
  `KS01_ASSERT_HOLDS(a_upd_addr, (rd_vld_r && rd_upd_r), (32'(lag_addr_r) >= 32'(wgt_r)), "ks01_dp: update write below object weight")
  `KS01_ASSERT_HOLDS(a_upd_mono, (rd_vld_r && rd_upd_r), (wdata >= rdata_a), "ks01_dp: update lowered a table entry")

endmodule

// ===== tb/knapsack_01_dp_tb.sv =====
// self-checking testbench for the 0/1 knapsack engine knapsack_01_dp
// depends on ks01_pkg and the engine rtl; a scoreboard class predicts every case result

typedef struct {
  ks01_pkg::sum_t value;
  ks01_pkg::wgt_t weight;
} best_fill_t;

// keeps its own best-value-by-capacity table and the results still owed by the engine
class knapsack_board;
  ks01_pkg::sum_t best_fill [ks01_pkg::MAX_CAPACITY_ENTRIES];
  ks01_pkg::cap_t capacity;
  best_fill_t     owed_results [$];
  int             errors;
  int             results_checked;

  function new();
    foreach (best_fill[i]) best_fill[i] = '0;
    capacity        = ks01_pkg::CAP_RESET;
    errors          = 0;
    results_checked = 0;
  endfunction

  // fold one accepted object into the table, queue a result on the last one
  function void take_object(ks01_pkg::val_t v, ks01_pkg::wgt_t w, logic last);
    int          top;
    int          c;
    logic [32:0] cand;
    best_fill_t  res;
    top = int'(capacity);
    if (top > ks01_pkg::MAX_CAPACITY_ENTRIES - 1) top = ks01_pkg::MAX_CAPACITY_ENTRIES - 1;
    if (int'(w) <= top) begin
      // top down so each object counts once
      for (c = top; c >= int'(w); c--) begin
        cand = {1'b0, best_fill[c - int'(w)]} + 33'(v);
        if (cand[32]) cand = {1'b0, 32'hFFFF_FFFF};
        if (cand[31:0] > best_fill[c]) best_fill[c] = cand[31:0];
      end
    end
    if (last) begin
      res.value  = '0;
      res.weight = '0;
      for (c = 0; c <= top; c++) begin
        if (best_fill[c] > res.value) begin
          res.value  = best_fill[c];
          res.weight = ks01_pkg::wgt_t'(c);
        end
      end
      owed_results.push_back(res);
      foreach (best_fill[i]) best_fill[i] = '0;
    end
  endfunction

  function void check_result(ks01_pkg::sum_t value, ks01_pkg::wgt_t weight);
    best_fill_t exp_res;
    if (owed_results.size() == 0) begin
      $display("%0t: result with none owed: best_value %0d best_weight %0d",
               $time, value, weight);
      errors++;
      return;
    end
    exp_res = owed_results.pop_front();
    results_checked++;
    if (value !== exp_res.value) begin
      $display("%0t: best_value mismatch: expected %0d, actual %0d",
               $time, exp_res.value, value);
      errors++;
    end
    if (weight !== exp_res.weight) begin
      $display("%0t: best_weight mismatch: expected %0d, actual %0d",
               $time, exp_res.weight, weight);
      errors++;
    end
  endfunction
endclass

module knapsack_01_dp_tb;
  import ks01_pkg::*;

  localparam int SETTLE_CYCLES = 1100;
  // slowest run: ~400 objects, each a full update pass and possibly closing a
  // case with a scan, plus stalls, pauses and settles; taken several times over
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int DENSE_OBJECTS = 30;
  localparam int PHASE_OBJECTS = 45;

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   in_valid       = 1'b0;
  logic   in_stall;
  val_t   in_item_value  = '0;
  wgt_t   in_item_weight = '0;
  logic   in_last_item   = 1'b0;
  logic   out_valid;
  logic   out_stall      = 1'b0;
  sum_t   out_best_value;
  wgt_t   out_best_weight;
  logic   cfg_valid      = 1'b0;
  logic   cfg_ready;
  cap_t   cfg_capacity   = '0;

  knapsack_board board = new();

  bit     idle_on = 1'b1;  // random gaps on both channels
  int     cycles;
  int     objects_sent;
  int     cases_sent;
  int     settings_used;

  knapsack_01_dp dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item_value   (in_item_value),
    .in_item_weight  (in_item_weight),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_value  (out_best_value),
    .out_best_weight (out_best_weight),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog on the cycle count
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycles, board.owed_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result side stalls about a third of the cycles while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 34);
    end
  end

  // every result transfer is checked against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_best_value, out_best_weight);
    end
  end

  // one object transfer, with random idle cycles ahead of it
  task automatic send_object(input val_t v, input wgt_t w, input logic last);
    while (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_item_value  <= v;
    in_item_weight <= w;
    in_last_item   <= last;
    do @(posedge clk); while (in_stall);
    board.take_object(v, w, last);
    objects_sent++;
    if (last) cases_sent++;
  endtask

  // capacity write; only called with the engine idle
  task automatic write_capacity(input cap_t c);
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    board.capacity = c;
    settings_used++;
  endtask

  // wait out owed results, then the longest object still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic val_t rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return val_t'($urandom());
  endfunction

  // mostly fitting weights, some at the edges, some above the capacity
  function automatic wgt_t rand_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return wgt_t'($urandom_range(0, int'(board.capacity)));
    if (pick < 78) return '0;
    if (pick < 86) return board.capacity;
    return wgt_t'($urandom());
  endfunction

  // cases of 1 to 8 objects; an open phase ends in the middle of a case
  task automatic run_phase(input int n_objects, input bit leave_open);
    int   left_in_case;
    int   k;
    logic last;
    left_in_case = $urandom_range(1, 8);
    for (k = 0; k < n_objects; k++) begin
      left_in_case--;
      last = (left_in_case == 0);
      if (k == n_objects - 1) last = !leave_open;
      send_object(rand_value(), rand_weight(), last);
      if (last) left_in_case = $urandom_range(1, 8);
    end
  endtask

  initial begin
    cap_t phase_caps [8];
    int   k;
    objects_sent  = 0;
    cases_sent    = 0;
    settings_used = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // the engine clears its table after reset with in_stall high
    do @(posedge clk); while (in_stall);

    // directed cases at the reset capacity of 1023
    // all values zero gives value 0 at weight 0
    send_object('0, '0, 1'b1);
    // zero weight adds once everywhere, heaviest object fills the top entry
    send_object('1, '0, 1'b0);
    send_object('1, wgt_t'(1023), 1'b0);
    send_object(val_t'(1), wgt_t'(1), 1'b1);

    // capacity lowered in the middle of a case, upper entries kept but ignored
    send_object(val_t'(100), wgt_t'(600), 1'b0);
    settle();
    write_capacity(cap_t'(500));
    send_object(val_t'(7), wgt_t'(3), 1'b1);

    // objects heavier than the capacity change nothing
    settle();
    write_capacity(cap_t'(5));
    send_object(val_t'(50), wgt_t'(10), 1'b0);
    send_object(val_t'(20), wgt_t'(5), 1'b0);
    send_object(val_t'(30), wgt_t'(2), 1'b0);
    send_object(val_t'(40), wgt_t'(3), 1'b1);

    // capacity zero, only weightless objects count
    settle();
    write_capacity(cap_t'(0));
    send_object(val_t'(9), '0, 1'b0);
    send_object('0, wgt_t'(1), 1'b0);
    send_object(val_t'(65535), wgt_t'(1023), 1'b1);

    // the long stretch with no idling on either side, small capacity
    settle();
    idle_on = 1'b0;
    write_capacity(cap_t'(40));
    run_phase(DENSE_OBJECTS, 1'b0);
    settle();
    idle_on = 1'b1;

    // random phases over several capacities, the extremes among them
    phase_caps[0] = cap_t'(1023);
    phase_caps[1] = cap_t'(0);
    phase_caps[2] = cap_t'(1);
    phase_caps[3] = cap_t'($urandom_range(2, 15));
    phase_caps[4] = cap_t'($urandom_range(16, 100));
    phase_caps[5] = cap_t'($urandom_range(101, 400));
    phase_caps[6] = cap_t'(512);
    phase_caps[7] = cap_t'(1023);
    for (k = 0; k < 8; k++) begin
      write_capacity(phase_caps[k]);
      run_phase(PHASE_OBJECTS, (k != 7) && ($urandom_range(1) == 1));
      settle();
    end

    $display("%0d objects in %0d cases over %0d capacity writes", objects_sent, cases_sent,
             settings_used);
    $display("%0d results checked, capacities 0 to 1023 incl. mid-case capacity changes",
             board.results_checked);
    if (board.errors == 0 && board.owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
